// ===== hdl/min_heap_priority_queue_unit_assert.svh =====
// ----------------------------------------------------------------------------
// min-heap priority queue assertion macros
// shared property templates for the port checker
// ----------------------------------------------------------------------------
`ifndef MIN_HEAP_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define MIN_HEAP_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// same-cycle implication, held off while reset is low
`define HPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heap queue check failed");

// next-cycle implication, held off while reset is low
`define HPQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heap queue check failed");

`endif

// ===== hdl/hpq_pkg.sv =====
// ----------------------------------------------------------------------------
// hpq_pkg
// shared types and constants of the min-heap priority queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hpq_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;

    // request operation codes
    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_CMP,
        S_POP_LAST,
        S_DN_CMP,
        S_PLACE,
        S_DONE
    } t_state;

    // one result item
    typedef struct packed {
        logic signed [VALUE_W-1:0] min_value;
        logic [COUNT_W-1:0]        count;
        logic                      empty_res;
        t_status                   status;
    } t_result;

endpackage

// ===== hdl/hpq_req_if.sv =====
// ----------------------------------------------------------------------------
// hpq_req_if
// request channel: push or pop with its value
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hpq_req_if;
    logic                                valid;
    logic                                ready;
    logic                                mode;
    logic signed [hpq_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

// ===== hdl/hpq_res_if.sv =====
// ----------------------------------------------------------------------------
// hpq_res_if
// result channel: minimum, count, empty flag and status
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hpq_res_if;
    logic                                valid;
    logic                                ready;
    logic signed [hpq_pkg::VALUE_W-1:0]  min_value;
    logic [hpq_pkg::COUNT_W-1:0]         count;
    logic                                empty_res;
    logic [1:0]                          status;

    modport source (output valid, output min_value, output count, output empty_res,
                    output status, input ready);
    modport sink   (input valid, input min_value, input count, input empty_res,
                    input status, output ready);
endinterface

// ===== hdl/hpq_mem.sv =====
// ----------------------------------------------------------------------------
// hpq_mem
// heap storage: one write port, two registered read ports
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpq_mem #(
    parameter int AW = 7
) (
    input  logic                                i_clk,
    input  logic                                i_wr_en,
    input  logic [AW-1:0]                       i_wr_addr,
    input  logic signed [hpq_pkg::VALUE_W-1:0]  i_wr_data,
    input  logic [AW-1:0]                       i_rd_addr_a,
    input  logic [AW-1:0]                       i_rd_addr_b,
    output logic signed [hpq_pkg::VALUE_W-1:0]  o_rd_data_a,
    output logic signed [hpq_pkg::VALUE_W-1:0]  o_rd_data_b
);

    logic signed [hpq_pkg::VALUE_W-1:0] r_mem [2**AW];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read ports, both registered
    always_ff @(posedge i_clk) begin
        o_rd_data_a <= r_mem[i_rd_addr_a];
        o_rd_data_b <= r_mem[i_rd_addr_b];
    end

endmodule

// ===== hdl/hpq_core.sv =====
// ----------------------------------------------------------------------------
// hpq_core
// sequencer for push sift-up and pop sift-down over the heap memory
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpq_core #(
    parameter int CAPACITY = 127,
    parameter int AW       = 7
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request side
    input  logic                                i_req_valid,
    output logic                                o_req_ready,
    input  logic                                i_req_mode,
    input  logic signed [hpq_pkg::VALUE_W-1:0]  i_req_value,
    // result side
    output logic                                o_res_valid,
    input  logic                                i_res_ready,
    output hpq_pkg::t_result                    o_res,
    // memory side
    output logic                                o_wr_en,
    output logic [AW-1:0]                       o_wr_addr,
    output logic signed [hpq_pkg::VALUE_W-1:0]  o_wr_data,
    output logic [AW-1:0]                       o_rd_addr_a,
    output logic [AW-1:0]                       o_rd_addr_b,
    input  logic signed [hpq_pkg::VALUE_W-1:0]  i_rd_data_a,
    input  logic signed [hpq_pkg::VALUE_W-1:0]  i_rd_data_b
);

    hpq_pkg::t_state                    r_state, n_state;
    hpq_pkg::t_status                   r_status, n_status;
    logic [AW-1:0]                      r_count, n_count;
    logic [AW-1:0]                      r_pos, n_pos;
    logic signed [hpq_pkg::VALUE_W-1:0] r_val, n_val;
    logic signed [hpq_pkg::VALUE_W-1:0] r_root;

    logic [AW-1:0]                      w_cnt_inc;
    logic [AW-1:0]                      w_parent;
    logic [AW:0]                        w_left;
    logic                               w_has_right;
    logic                               w_pick_right;
    logic signed [hpq_pkg::VALUE_W-1:0] w_pick_val;
    logic [AW-1:0]                      w_pick_addr;
    logic [AW:0]                        w_next_left;
    logic [AW:0]                        w_next_right;
    logic [hpq_pkg::COUNT_W+AW-1:0]     w_cnt_ext;

    // index arithmetic for both sift directions
    assign w_cnt_inc    = r_count + AW'(1);
    assign w_parent     = r_pos >> 1;
    assign w_left       = {r_pos, 1'b0};
    assign w_has_right  = w_left < {1'b0, r_count};
    // ties go to the right child
    assign w_pick_right = w_has_right && !(i_rd_data_a < i_rd_data_b);
    assign w_pick_val   = w_pick_right ? i_rd_data_b : i_rd_data_a;
    assign w_pick_addr  = w_pick_right ? (w_left[AW-1:0] + AW'(1)) : w_left[AW-1:0];
    assign w_next_left  = {w_pick_addr, 1'b0};
    assign w_next_right = w_next_left + (AW+1)'(1);

    // next state and memory control
    always_comb begin
        n_state     = r_state;
        n_status    = r_status;
        n_count     = r_count;
        n_pos       = r_pos;
        n_val       = r_val;
        o_req_ready = 1'b0;
        o_res_valid = 1'b0;
        o_wr_en     = 1'b0;
        o_wr_addr   = r_pos;
        o_wr_data   = r_val;
        o_rd_addr_a = r_pos;
        o_rd_addr_b = r_pos;
        unique case (r_state)
            hpq_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_status = hpq_pkg::STAT_OK;
                    if (i_req_mode == hpq_pkg::MODE_PUSH) begin
                        if (r_count == AW'(CAPACITY)) begin
                            n_status = hpq_pkg::STAT_FULL;
                            n_state  = hpq_pkg::S_DONE;
                        end else begin
                            n_count = w_cnt_inc;
                            n_pos   = w_cnt_inc;
                            n_val   = i_req_value;
                            if (w_cnt_inc == AW'(1)) begin
                                o_wr_en   = 1'b1;
                                o_wr_addr = AW'(1);
                                o_wr_data = i_req_value;
                                n_state   = hpq_pkg::S_DONE;
                            end else begin
                                o_rd_addr_a = w_cnt_inc >> 1;
                                n_state     = hpq_pkg::S_UP_CMP;
                            end
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = hpq_pkg::STAT_EMPTY;
                            n_state  = hpq_pkg::S_DONE;
                        end else begin
                            n_count = r_count - AW'(1);
                            if (r_count == AW'(1)) begin
                                n_state = hpq_pkg::S_DONE;
                            end else begin
                                // fetch the last entry to move to the root
                                o_rd_addr_a = r_count;
                                n_state     = hpq_pkg::S_POP_LAST;
                            end
                        end
                    end
                end
            end
            hpq_pkg::S_UP_CMP: begin
                if (r_val < i_rd_data_a) begin
                    // parent moves down into the hole
                    o_wr_en     = 1'b1;
                    o_wr_data   = i_rd_data_a;
                    n_pos       = w_parent;
                    o_rd_addr_a = w_parent >> 1;
                    if (w_parent == AW'(1)) begin
                        n_state = hpq_pkg::S_PLACE;
                    end
                end else begin
                    o_wr_en = 1'b1;
                    n_state = hpq_pkg::S_DONE;
                end
            end
            hpq_pkg::S_POP_LAST: begin
                n_val = i_rd_data_a;
                n_pos = AW'(1);
                if (r_count < AW'(2)) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = AW'(1);
                    o_wr_data = i_rd_data_a;
                    n_state   = hpq_pkg::S_DONE;
                end else begin
                    o_rd_addr_a = AW'(2);
                    o_rd_addr_b = AW'(3);
                    n_state     = hpq_pkg::S_DN_CMP;
                end
            end
            hpq_pkg::S_DN_CMP: begin
                if (r_val > w_pick_val) begin
                    // smaller child moves up into the hole
                    o_wr_en     = 1'b1;
                    o_wr_data   = w_pick_val;
                    n_pos       = w_pick_addr;
                    o_rd_addr_a = w_next_left[AW-1:0];
                    o_rd_addr_b = w_next_right[AW-1:0];
                    if (w_next_left > {1'b0, r_count}) begin
                        n_state = hpq_pkg::S_PLACE;
                    end
                end else begin
                    o_wr_en = 1'b1;
                    n_state = hpq_pkg::S_DONE;
                end
            end
            hpq_pkg::S_PLACE: begin
                o_wr_en = 1'b1;
                n_state = hpq_pkg::S_DONE;
            end
            hpq_pkg::S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = hpq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = hpq_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hpq_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_pos    <= n_pos;
        r_val    <= n_val;
    end

    // shadow copy of the root entry
    always_ff @(posedge i_clk) begin
        if (o_wr_en && (o_wr_addr == AW'(1))) begin
            r_root <= o_wr_data;
        end
    end

    // result item
    assign w_cnt_ext       = {{hpq_pkg::COUNT_W{1'b0}}, r_count};
    assign o_res.min_value = (r_count != '0) ? r_root : '0;
    assign o_res.count     = w_cnt_ext[hpq_pkg::COUNT_W-1:0];
    assign o_res.empty_res = (r_count == '0);
    assign o_res.status    = r_status;

endmodule

// ===== hdl/hpq_out.sv =====
// ----------------------------------------------------------------------------
// hpq_out
// output register between the sequencer and the result channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpq_out (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  hpq_pkg::t_result i_res,
    output logic             o_valid,
    input  logic             i_ready,
    output hpq_pkg::t_result o_res
);

    logic             r_valid;
    hpq_pkg::t_result r_res;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_res <= i_res;
        end
    end

endmodule

// ===== hdl/min_heap_priority_queue_unit.sv =====
// Min-heap priority queue of signed 32-bit values, up to CAPACITY entries held
// in one dual-read, single-write memory. A push sifts the new value up; a pop
// moves the last entry to the root and sifts it down. Each level of the sift
// loop is one memory read, a compare and a write-back. A request that needs no
// sift (the first push, a push into a full heap, a pop from an empty heap, a
// pop of the only entry) goes straight to its result, and a pop that leaves a
// single entry only moves the last entry to the root. The sequencer takes no
// new request until it has handed on the result of the last one. A finished
// result sits in an output register, so a new request is taken while the
// previous result waits. Storage needs no clearing after reset.
// ----------------------------------------------------------------------------
// min_heap_priority_queue_unit
// push / pop-min priority queue built around a binary heap memory
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module min_heap_priority_queue_unit #(
    parameter int CAPACITY = 127
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hpq_req_if.sink    i_req,
    hpq_res_if.source  o_res
);

    localparam int AW = $clog2(CAPACITY + 1);

    logic                               w_wr_en;
    logic [AW-1:0]                      w_wr_addr;
    logic signed [hpq_pkg::VALUE_W-1:0] w_wr_data;
    logic [AW-1:0]                      w_rd_addr_a;
    logic [AW-1:0]                      w_rd_addr_b;
    logic signed [hpq_pkg::VALUE_W-1:0] w_rd_data_a;
    logic signed [hpq_pkg::VALUE_W-1:0] w_rd_data_b;
    logic                               w_core_valid;
    logic                               w_core_ready;
    hpq_pkg::t_result                   w_core_res;
    hpq_pkg::t_result                   w_out_res;

    // sift sequencer
    hpq_core #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_req_mode  (i_req.mode),
        .i_req_value (i_req.value),
        .o_res_valid (w_core_valid),
        .i_res_ready (w_core_ready),
        .o_res       (w_core_res),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .o_rd_addr_a (w_rd_addr_a),
        .o_rd_addr_b (w_rd_addr_b),
        .i_rd_data_a (w_rd_data_a),
        .i_rd_data_b (w_rd_data_b)
    );

    // heap storage
    hpq_mem #(
        .AW (AW)
    ) u_mem (
        .i_clk       (i_clk),
        .i_wr_en     (w_wr_en),
        .i_wr_addr   (w_wr_addr),
        .i_wr_data   (w_wr_data),
        .i_rd_addr_a (w_rd_addr_a),
        .i_rd_addr_b (w_rd_addr_b),
        .o_rd_data_a (w_rd_data_a),
        .o_rd_data_b (w_rd_data_b)
    );

    // result register
    hpq_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_core_valid),
        .o_ready (w_core_ready),
        .i_res   (w_core_res),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_res   (w_out_res)
    );

    assign o_res.min_value = w_out_res.min_value;
    assign o_res.count     = w_out_res.count;
    assign o_res.empty_res = w_out_res.empty_res;
    assign o_res.status    = w_out_res.status;

endmodule

// ===== hdl/hpq_checker.sv =====
// ----------------------------------------------------------------------------
// hpq_checker
// port-level checks on the result channel of the heap queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "min_heap_priority_queue_unit_assert.svh"

module hpq_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_res_valid,
    input  logic                                i_res_ready,
    input  logic signed [hpq_pkg::VALUE_W-1:0]  i_min_value,
    input  logic [hpq_pkg::COUNT_W-1:0]         i_count,
    input  logic                                i_empty_res,
    input  logic [1:0]                          i_status
);

    // a stalled result holds
    `HPQ_ASSERT_NXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid && $stable(i_min_value) && $stable(i_count) && $stable(i_status) && $stable(i_empty_res))

    // an empty heap reports zero count and zero minimum
    `HPQ_ASSERT_IMP(a_empty_zero, i_clk, i_rst_n, i_res_valid && i_empty_res, (i_count == '0) && (i_min_value == '0))

    // a rejected pop only happens on an empty heap
    `HPQ_ASSERT_IMP(a_pop_empty, i_clk, i_rst_n, i_res_valid && (i_status == hpq_pkg::STAT_EMPTY), i_empty_res)

    // a dropped push only happens on a non-empty heap
    `HPQ_ASSERT_IMP(a_push_full, i_clk, i_rst_n, i_res_valid && (i_status == hpq_pkg::STAT_FULL), !i_empty_res)

endmodule

bind min_heap_priority_queue_unit hpq_checker u_hpq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_min_value (o_res.min_value),
    .i_count     (o_res.count),
    .i_empty_res (o_res.empty_res),
    .i_status    (o_res.status)
);

// ===== tb/tb_min_heap_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// tb_min_heap_priority_queue_unit
// self-checking bench for the push / pop-min heap priority queue
//
// A short table of directed requests (empty pop after reset, extreme values,
// duplicates, drain to empty) runs first. Random traffic follows, in fill,
// drain, balanced and noise segments, so that the heap often runs full and
// empty. A behavioral heap predicts every result. Idling on both channels
// changes by phase, and once the result side holds off long enough to
// back-pressure the request side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_min_heap_priority_queue_unit;

    import hpq_pkg::*;

    localparam int      HEAP_CAP     = 127;
    localparam int      RAND_ITEMS   = 1825;
    localparam int      LONG_HOLD    = 400;
    localparam int      DRAIN_CYCLES = 16;
    localparam int      MAX_REPORTS  = 10;
    localparam longint  TIMEOUT_NS   = 5000000;

    // one row of the directed table
    typedef struct {
        logic                      op;
        logic signed [VALUE_W-1:0] val;
        bit                        fixed;
        t_result                   want;
    } dir_row_t;

    logic i_clk;
    logic i_rst_n;

    hpq_req_if req_if ();
    hpq_res_if res_if ();

    min_heap_priority_queue_unit #(
        .CAPACITY (HEAP_CAP)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    // behavioral heap, slot 0 unused
    logic signed [VALUE_W-1:0] heap_mem [0:HEAP_CAP];
    int                        heap_fill;

    t_result  pending_results [$];
    dir_row_t dir_rows [$];
    int       mismatch_cnt;
    int       send_idle_pct;
    int       recv_stall_pct;
    int       hold_req;

    // clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    initial begin
        #(TIMEOUT_NS);
        $display("== FAIL ==");
        $finish;
    end

    function automatic void heap_swap(int a, int b);
        logic signed [VALUE_W-1:0] tmp;
        tmp         = heap_mem[a];
        heap_mem[a] = heap_mem[b];
        heap_mem[b] = tmp;
    endfunction

    // apply one request to the behavioral heap and return its result
    function automatic t_result heap_apply(logic op, logic signed [VALUE_W-1:0] val);
        t_result r;
        int      pos;
        int      left;
        int      pick;
        r.status = STAT_OK;
        if (op == MODE_PUSH) begin
            if (heap_fill >= HEAP_CAP) begin
                r.status = STAT_FULL;
            end else begin
                heap_fill++;
                heap_mem[heap_fill] = val;
                pos = heap_fill;
                // sift up while strictly smaller than the parent
                while (pos > 1) begin
                    if (heap_mem[pos] < heap_mem[pos / 2]) begin
                        heap_swap(pos, pos / 2);
                        pos = pos / 2;
                    end else begin
                        break;
                    end
                end
            end
        end else begin
            if (heap_fill == 0) begin
                r.status = STAT_EMPTY;
            end else begin
                heap_mem[1] = heap_mem[heap_fill];
                heap_fill--;
                pos = 1;
                // sift down toward the smaller child, right one on a tie
                while (1) begin
                    left = pos * 2;
                    if (left > heap_fill) break;
                    if (left + 1 > heap_fill)
                        pick = left;
                    else if (heap_mem[left] < heap_mem[left + 1])
                        pick = left;
                    else
                        pick = left + 1;
                    if (heap_mem[pos] > heap_mem[pick]) begin
                        heap_swap(pos, pick);
                        pos = pick;
                    end else begin
                        break;
                    end
                end
            end
        end
        r.min_value = (heap_fill != 0) ? heap_mem[1] : '0;
        r.count     = COUNT_W'(heap_fill);
        r.empty_res = (heap_fill == 0);
        return r;
    endfunction

    function automatic dir_row_t make_row(logic op, logic signed [VALUE_W-1:0] val,
                                          bit fixed, logic signed [VALUE_W-1:0] mv,
                                          int cnt, logic emp, t_status st);
        dir_row_t row;
        row.op             = op;
        row.val            = val;
        row.fixed          = fixed;
        row.want.min_value = mv;
        row.want.count     = COUNT_W'(cnt);
        row.want.empty_res = emp;
        row.want.status    = st;
        return row;
    endfunction

    // value mix: extremes, a narrow band full of duplicates, and full range
    function automatic logic signed [VALUE_W-1:0] rand_value();
        logic signed [VALUE_W-1:0] v;
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(4))
                    0:       v = 32'sh7FFF_FFFF;
                    1:       v = 32'sh8000_0000;
                    2:       v = 32'sh0000_0000;
                    3:       v = -32'sd1;
                    default: v = 32'sd1;
                endcase
            end
            1, 2:    v = $signed($urandom_range(15)) - 32'sd8;
            default: v = $urandom();
        endcase
        return v;
    endfunction

    // offer one request and wait for the handshake, predicting on accept
    task automatic send_req(logic op, logic signed [VALUE_W-1:0] val, bit fixed,
                            t_result fixed_want);
        t_result r;
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.mode  <= op;
        req_if.value <= val;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        r = heap_apply(op, val);
        pending_results.push_back(fixed ? fixed_want : r);
        @(negedge i_clk);
    endtask

    task automatic report_mismatch(string what, t_result want);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
            $display("%0t mismatch (%s): want min=%0d cnt=%0d empty=%0b st=%0d, got min=%0d cnt=%0d empty=%0b st=%0d",
                     $realtime, what, want.min_value, want.count, want.empty_res,
                     want.status, res_if.min_value, res_if.count, res_if.empty_res,
                     res_if.status);
    endtask

    // result side ready, with random stalls and one long hold-off on request
    initial begin : result_ready_drive
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left == 0 && hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                want = '0;
                report_mismatch("unexpected", want);
            end else begin
                want = pending_results.pop_front();
                if (res_if.min_value !== want.min_value || res_if.count !== want.count ||
                    res_if.empty_res !== want.empty_res || res_if.status !== want.status)
                    report_mismatch("fields", want);
            end
        end
    end

    // stimulus
    initial begin : stimulus
        int                        rand_sent;
        int                        seg_left;
        int                        push_pct;
        int                        phase;
        logic                      op;
        logic signed [VALUE_W-1:0] val;
        t_result                   none;

        none           = '0;
        mismatch_cnt   = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 0;
        heap_fill      = 0;
        i_rst_n        = 1'b0;
        req_if.valid  <= 1'b0;
        req_if.mode   <= MODE_PUSH;
        req_if.value  <= '0;

        // directed table: fixed rows are read off at a glance
        dir_rows.push_back(make_row(MODE_POP,  -32'sd1,        1, 0, 0, 1, STAT_EMPTY));
        dir_rows.push_back(make_row(MODE_PUSH, 32'sh7FFF_FFFF, 1, 32'sh7FFF_FFFF, 1, 0,
                                    STAT_OK));
        dir_rows.push_back(make_row(MODE_PUSH, 32'sh8000_0000, 1, 32'sh8000_0000, 2, 0,
                                    STAT_OK));
        dir_rows.push_back(make_row(MODE_PUSH, 32'sd0,         0, 0, 0, 0, STAT_OK));
        dir_rows.push_back(make_row(MODE_PUSH, -32'sd1,        0, 0, 0, 0, STAT_OK));
        dir_rows.push_back(make_row(MODE_PUSH, 32'sd1,         0, 0, 0, 0, STAT_OK));
        dir_rows.push_back(make_row(MODE_PUSH, 32'sd5,         0, 0, 0, 0, STAT_OK));
        dir_rows.push_back(make_row(MODE_PUSH, 32'sd5,         0, 0, 0, 0, STAT_OK));
        dir_rows.push_back(make_row(MODE_PUSH, -32'sd7,        0, 0, 0, 0, STAT_OK));
        dir_rows.push_back(make_row(MODE_PUSH, 32'sh8000_0000, 0, 0, 0, 0, STAT_OK));
        dir_rows.push_back(make_row(MODE_PUSH, 32'sh5555_5555, 0, 0, 0, 0, STAT_OK));
        dir_rows.push_back(make_row(MODE_PUSH, 32'shAAAA_AAAA, 0, 0, 0, 0, STAT_OK));
        for (int i = 0; i < 10; i++)
            dir_rows.push_back(make_row(MODE_POP, 32'shDEAD_BEEF, 0, 0, 0, 0, STAT_OK));
        dir_rows.push_back(make_row(MODE_POP,  32'sh7FFF_FFFF, 1, 0, 0, 1, STAT_OK));
        dir_rows.push_back(make_row(MODE_POP,  32'sh8000_0000, 1, 0, 0, 1, STAT_EMPTY));

        // synchronous reset
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i])
            send_req(dir_rows[i].op, dir_rows[i].val, dir_rows[i].fixed, dir_rows[i].want);

        // random segments biased toward filling or draining the heap
        rand_sent = 0;
        seg_left  = 0;
        push_pct  = 50;
        while (rand_sent < RAND_ITEMS) begin
            if (seg_left == 0) begin
                case ($urandom_range(3))
                    0: begin push_pct = 92; seg_left = $urandom_range(100, 220); end
                    1: begin push_pct = 8;  seg_left = $urandom_range(100, 220); end
                    2: begin push_pct = 50; seg_left = $urandom_range(20, 80);   end
                    default: begin
                        push_pct = $urandom_range(100);
                        seg_left = $urandom_range(10, 40);
                    end
                endcase
            end
            seg_left--;

            // idling phases
            phase = rand_sent * 4 / RAND_ITEMS;
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            if (rand_sent == 150)
                hold_req++;

            op  = ($urandom_range(99) < push_pct) ? MODE_PUSH : MODE_POP;
            val = rand_value();
            send_req(op, val, 0, none);
            rand_sent++;
        end
        req_if.valid <= 1'b0;

        // wait for every result, then keep watching for strays
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
